// ----- rtl/core/size_class_free_list_allocator_defines.svh -----
// assertion macros for the size class allocator
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCFLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCFLA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SCFLA_ASSERT(lbl, prop, msg)
`define SCFLA_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/core/scfla_pkg.sv -----
// shared types and codes of the size class allocator
package scfla_pkg;
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOPAGE = 2'd2;
	localparam int HDR_BYTES = 4;

	typedef struct packed {
		logic is_free;
		logic bad;
	} dec_flags_t;
endpackage

// ----- rtl/core/scfla_ram.sv -----
// generic single write, single read ram with registered read
module scfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/scfla_decode.sv -----
// request decode: size rounding, class and header granule checks
module scfla_decode import scfla_pkg::*; #(
	parameter int GRANULE_BYTES = 8,
	parameter int PAGE_BYTES = 4096,
	parameter int NUM_CLASSES = 512,
	parameter int POOL_PAGES = 16
) (
	input  logic                     func,
	input  logic [11:0]              request_size,
	input  logic [15:0]              user_address,
	output dec_flags_t               flags,
	output logic [$clog2(PAGE_BYTES/GRANULE_BYTES+1)-1:0] objg,
	output logic [$clog2(NUM_CLASSES)-1:0] cls,
	output logic [$clog2(POOL_PAGES*(PAGE_BYTES/GRANULE_BYTES))-1:0] gran
);
	localparam int GSH = $clog2(GRANULE_BYTES);
	localparam int PG = PAGE_BYTES / GRANULE_BYTES;
	localparam int POOLG = POOL_PAGES * PG;
	localparam int OGW = $clog2(PG + 1);
	localparam int CW = $clog2(NUM_CLASSES);
	localparam int GW = $clog2(POOLG);

	logic [13:0] sum;
	logic [13:0] rnd;
	logic [15:0] base;
	logic [15:0] gsel;
	logic        bad_alloc;
	logic        bad_free;

	always_comb begin
		sum = 14'(request_size) + 14'(HDR_BYTES + GRANULE_BYTES - 1);
		rnd = sum >> GSH;
		bad_alloc = (request_size == 12'd0) || (rnd > 14'(PG))
			|| (({18'd0, rnd} - 32'd1) >= 32'(NUM_CLASSES));
		base = user_address - 16'(HDR_BYTES);
		gsel = base >> GSH;
		bad_free = {16'd0, gsel} >= 32'(POOLG);
		flags.is_free = (func == FUNC_FREE);
		flags.bad = (func == FUNC_FREE) ? bad_free : bad_alloc;
		objg = OGW'(rnd);
		cls = CW'(rnd - 14'd1);
		gran = GW'(gsel);
	end
endmodule

// ----- rtl/core/size_class_free_list_allocator.sv -----
// top level of the size class free list allocator
// usage:
// s_* takes requests: tuser is the function (allocate or free), tdata holds
// request_size and user_address. m_* returns one result per request with
// block_address and status in tdata.
// one request is in flight at a time. an allocate that hits its free list
// passes S_AHIT, S_APOP and S_DONE before its result, a free passes S_FRD,
// S_FHEAD and S_DONE, and a request rejected at decode goes straight to
// S_DONE. an allocate that carves a new page writes one link per cycle into
// the granule memory in S_CHAIN, paced by the single read and write port of
// each memory. after reset the list head memory is cleared, one class per
// cycle, and no request is taken until that is done.
// a finished result sits in the output register; the next request is
// accepted while it waits, and its own result holds until m_tready.
module size_class_free_list_allocator import scfla_pkg::*; #(
	parameter int GRANULE_BYTES = 8,
	parameter int PAGE_BYTES = 4096,
	parameter int NUM_CLASSES = 512,
	parameter int POOL_PAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_size[11:0], user_address[27:12], zero
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // block_address[15:0], status[17:16], zero
);
	`include "size_class_free_list_allocator_defines.svh"

	localparam int GSH = $clog2(GRANULE_BYTES);
	localparam int PG = PAGE_BYTES / GRANULE_BYTES;
	localparam int POOLG = POOL_PAGES * PG;
	localparam int OGW = $clog2(PG + 1);
	localparam int OFW = $clog2(3 * PG + 1);
	localparam int CW = $clog2(NUM_CLASSES);
	localparam int GW = $clog2(POOLG);
	localparam int PCW = $clog2(POOL_PAGES + 1);
	localparam int LW = $clog2(POOLG + 1);
	localparam int SZW = $clog2(PAGE_BYTES + 1);
	localparam int WW = (LW > SZW) ? LW : SZW;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_AHIT, S_APOP, S_CHAIN, S_REM, S_FRD, S_FHEAD, S_DONE
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    clr_q;
	logic [OGW-1:0]   objg_q;
	logic [CW-1:0]    cls_q;
	logic [GW-1:0]    gran_q;
	logic [GW-1:0]    gran0_q;
	logic [OFW-1:0]   offg_q;
	logic [PCW-1:0]   cursor_q;
	logic [15:0]      res_addr_q;
	logic [1:0]       res_status_q;

	dec_flags_t       dflags;
	logic [OGW-1:0]   dobjg;
	logic [CW-1:0]    dcls;
	logic [GW-1:0]    dgran;

	logic             hd_we, hd_re, wd_we, wd_re;
	logic [CW-1:0]    hd_waddr, hd_raddr;
	logic [GW-1:0]    wd_waddr, wd_raddr;
	logic [WW-1:0]    hd_wdata, hd_rdata, wd_wdata, wd_rdata;

	logic             accept;
	logic             head_hit;
	logic [WW-1:0]    real_sz;
	logic [OFW-1:0]   off_next;
	logic             chain_more;
	logic             chain_link;
	logic [WW-1:0]    szg;
	logic             size_ok;
	logic [CW-1:0]    fcls;
	logic [CW-1:0]    rcls;
	logic             out_free;
	logic [15:0]      page_addr;

	scfla_decode #(
		.GRANULE_BYTES(GRANULE_BYTES),
		.PAGE_BYTES(PAGE_BYTES),
		.NUM_CLASSES(NUM_CLASSES),
		.POOL_PAGES(POOL_PAGES)
	) u_decode (
		.func(s_tuser),
		.request_size(s_tdata[11:0]),
		.user_address(s_tdata[27:12]),
		.flags(dflags),
		.objg(dobjg),
		.cls(dcls),
		.gran(dgran)
	);

	scfla_ram #(.WIDTH(WW), .DEPTH(NUM_CLASSES)) u_heads (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata)
	);

	scfla_ram #(.WIDTH(WW), .DEPTH(POOLG)) u_words (
		.clk(clk), .we(wd_we), .waddr(wd_waddr), .wdata(wd_wdata),
		.re(wd_re), .raddr(wd_raddr), .rdata(wd_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		head_hit = (hd_rdata != '0) && (hd_rdata <= WW'(POOLG));
		real_sz = WW'(objg_q) << GSH;
		off_next = offg_q + OFW'(objg_q);
		chain_more = off_next <= OFW'(PG);
		chain_link = (off_next + OFW'(objg_q)) <= OFW'(PG);
		szg = wd_rdata >> GSH;
		size_ok = (wd_rdata >= WW'(GRANULE_BYTES)) && (wd_rdata <= WW'(PAGE_BYTES))
			&& ((32'(szg) - 32'd1) < 32'(NUM_CLASSES));
		fcls = CW'(szg - WW'(1));
		rcls = CW'(OFW'(PG) - offg_q - OFW'(1));
		page_addr = 16'((32'(gran0_q) << GSH) + 32'(HDR_BYTES));

		hd_we = 1'b0;
		hd_waddr = cls_q;
		hd_wdata = '0;
		hd_re = 1'b0;
		hd_raddr = dcls;
		wd_we = 1'b0;
		wd_waddr = gran_q;
		wd_wdata = real_sz;
		wd_re = 1'b0;
		wd_raddr = dgran;

		unique case (state_q)
			S_CLR: begin
				hd_we = 1'b1;
				hd_waddr = clr_q;
			end
			S_IDLE: begin
				if (accept && !dflags.bad) begin
					hd_re = !dflags.is_free;
					wd_re = dflags.is_free;
				end
			end
			S_AHIT: begin
				wd_re = head_hit;
				wd_raddr = GW'(hd_rdata - WW'(1));
			end
			S_APOP: begin
				hd_we = 1'b1;
				hd_wdata = wd_rdata;
				wd_we = 1'b1;
			end
			S_CHAIN: begin
				if (chain_more) begin
					wd_we = 1'b1;
					wd_waddr = gran0_q + GW'(offg_q);
					wd_wdata = chain_link
						? WW'(gran0_q) + WW'(off_next) + WW'(1) : '0;
				end else begin
					hd_we = 1'b1;
					hd_wdata = (offg_q == OFW'(objg_q))
						? '0 : WW'(gran0_q) + WW'(objg_q) + WW'(1);
					wd_we = 1'b1;
					wd_waddr = gran0_q;
					hd_re = offg_q < OFW'(PG);
					hd_raddr = rcls;
				end
			end
			S_REM: begin
				wd_we = 1'b1;
				wd_waddr = gran0_q + GW'(offg_q);
				wd_wdata = hd_rdata;
				hd_we = 1'b1;
				hd_waddr = rcls;
				hd_wdata = WW'(gran0_q) + WW'(offg_q) + WW'(1);
			end
			S_FRD: begin
				hd_re = size_ok;
				hd_raddr = fcls;
			end
			S_FHEAD: begin
				wd_we = 1'b1;
				wd_wdata = hd_rdata;
				hd_we = 1'b1;
				hd_wdata = WW'(gran_q) + WW'(1);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			cursor_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != S_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(NUM_CLASSES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						objg_q <= dobjg;
						cls_q <= dcls;
						gran_q <= dgran;
						res_addr_q <= '0;
						res_status_q <= ST_OK;
						if (dflags.bad) begin
							res_status_q <= ST_RANGE;
							state_q <= S_DONE;
						end else if (dflags.is_free) begin
							state_q <= S_FRD;
						end else begin
							state_q <= S_AHIT;
						end
					end
				end
				S_AHIT: begin
					if (head_hit) begin
						gran_q <= GW'(hd_rdata - WW'(1));
						state_q <= S_APOP;
					end else if (cursor_q >= PCW'(POOL_PAGES)) begin
						res_status_q <= ST_NOPAGE;
						state_q <= S_DONE;
					end else begin
						gran0_q <= GW'(cursor_q) * GW'(PG);
						offg_q <= OFW'(objg_q);
						cursor_q <= cursor_q + PCW'(1);
						state_q <= S_CHAIN;
					end
				end
				S_APOP: begin
					res_addr_q <= 16'((32'(gran_q) << GSH) + 32'(HDR_BYTES));
					state_q <= S_DONE;
				end
				S_CHAIN: begin
					if (chain_more) begin
						offg_q <= off_next;
					end else begin
						res_addr_q <= page_addr;
						state_q <= (offg_q < OFW'(PG)) ? S_REM : S_DONE;
					end
				end
				S_REM: begin
					state_q <= S_DONE;
				end
				S_FRD: begin
					cls_q <= fcls;
					if (size_ok) begin
						state_q <= S_FHEAD;
					end else begin
						res_status_q <= ST_RANGE;
						state_q <= S_DONE;
					end
				end
				S_FHEAD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata <= {6'd0, res_status_q, res_addr_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SCFLA_ASSERT(a_cursor_bound, cursor_q <= PCW'(POOL_PAGES), "page cursor overrun")
	`SCFLA_ASSERT(a_fail_addr_zero, (m_tvalid && m_tdata[17:16] != ST_OK) |-> (m_tdata[15:0] == 16'd0), "failed request with address")
	`SCFLA_NEVER(a_chain_in_page, (state_q == S_CHAIN) && wd_we && (32'(wd_waddr) >= 32'(gran0_q) + 32'(PG)), "link written outside page")
	`SCFLA_NEVER(a_no_req_while_clear, (state_q == S_CLR) && accept, "request during head clear")
endmodule

// ----- test/size_class_free_list_allocator_tb.sv -----
// self-checking testbench for the size class free list allocator
module size_class_free_list_allocator_tb;
	import scfla_pkg::*;

	localparam int GRAN = 8;
	localparam int PAGE = 4096;
	localparam int CLASSES = 512;
	localparam int PAGES = 16;
	localparam int POOL_GRAN = PAGES * PAGE / GRAN;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic        func;
		logic [11:0] size;
		logic [15:0] uaddr;
	} request_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [1:0]  status;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;

	size_class_free_list_allocator u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int heads[CLASSES];
	int words[POOL_GRAN];
	bit written[POOL_GRAN];
	int cursor;
	int live_blocks[$];

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int n_alloc = 0, n_free = 0, n_nopage = 0, n_range = 0;
	bit quiet_tail = 1'b0;
	bit hold_sink = 1'b0;
	int src_gap = 0, sink_gap = 0;

	function automatic void link_block(int cls, int g);
		if (cls >= CLASSES || g >= POOL_GRAN) return;
		words[g] = heads[cls];
		written[g] = 1'b1;
		heads[cls] = g + 1;
	endfunction

	function automatic outcome_t predict_allocate(int req);
		outcome_t o;
		int blk_bytes, cls, g, pbyte, obj, nblk, rest;
		o = '0;
		if (req == 0 || req >= 4096) begin
			o.status = ST_RANGE;
			return o;
		end
		blk_bytes = ((req + HDR_BYTES + GRAN - 1) / GRAN) * GRAN;
		cls = blk_bytes / GRAN - 1;
		if (blk_bytes > PAGE || cls >= CLASSES) begin
			o.status = ST_RANGE;
			return o;
		end
		if (heads[cls] != 0 && heads[cls] <= POOL_GRAN) begin
			g = heads[cls] - 1;
			heads[cls] = words[g];
			words[g] = blk_bytes;
			o.addr = 16'(g * GRAN + HDR_BYTES);
			return o;
		end
		if (cursor >= PAGES) begin
			o.status = ST_NOPAGE;
			return o;
		end
		pbyte = cursor * PAGE;
		cursor++;
		g = pbyte / GRAN;
		obj = blk_bytes / GRAN;
		nblk = PAGE / blk_bytes;
		rest = PAGE - nblk * blk_bytes;
		heads[cls] = 0;
		for (int i = nblk; i > 1; i--) link_block(cls, g + (i - 1) * obj);
		if (rest >= GRAN) link_block(rest / GRAN - 1, g + nblk * obj);
		words[g] = blk_bytes;
		written[g] = 1'b1;
		o.addr = 16'(pbyte + HDR_BYTES);
		return o;
	endfunction

	function automatic outcome_t predict_free(logic [15:0] ua);
		outcome_t o;
		logic [15:0] base;
		int g, sz;
		o = '0;
		base = ua - 16'(HDR_BYTES);
		g = base / GRAN;
		if (g >= POOL_GRAN) begin
			o.status = ST_RANGE;
			return o;
		end
		sz = words[g];
		if (sz < GRAN || sz > PAGE || (sz / GRAN - 1) >= CLASSES) begin
			o.status = ST_RANGE;
			return o;
		end
		link_block(sz / GRAN - 1, g);
		return o;
	endfunction

	// a stray free is safe if it falls outside the pool, or if its header is written and is not a size
	function automatic bit free_is_safe(logic [15:0] ua);
		logic [15:0] base;
		int g, sz;
		base = ua - 16'(HDR_BYTES);
		g = base / GRAN;
		if (g >= POOL_GRAN) return 1'b1;
		if (!written[g]) return 1'b0;
		sz = words[g];
		return sz < GRAN || sz > PAGE || (sz / GRAN - 1) >= CLASSES;
	endfunction

	function automatic void add_request(logic func, int sz, logic [15:0] ua);
		request_t r;
		r.func = func;
		r.size = sz[11:0];
		r.uaddr = ua;
		pending_requests.push_back(r);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				request_t r;
				outcome_t o;
				r = pending_requests.pop_front();
				o = r.func == FUNC_ALLOC ? predict_allocate(r.size) : predict_free(r.uaddr);
				expected_outcomes.push_back(o);
				if (r.func == FUNC_ALLOC && o.status == ST_OK) begin
					live_blocks.push_back(o.addr);
					n_alloc++;
				end
				if (r.func == FUNC_FREE && o.status == ST_OK) n_free++;
				if (o.status == ST_NOPAGE) n_nopage++;
				if (o.status == ST_RANGE) n_range++;
			end
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!quiet_tail && !(s_tvalid && !s_tready) && $urandom_range(0, 19) == 0) begin
				src_gap <= $urandom_range(0, 14);
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				request_t n;
				n = pending_requests[0];
				s_tvalid <= 1'b1;
				s_tuser <= n.func;
				s_tdata <= {4'b0, n.uaddr, n.size};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (m_tvalid && m_tready) begin
				outcome_t got;
				got.addr = m_tdata[15:0];
				got.status = m_tdata[17:16];
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result addr=%h status=%0d", $time, got.addr,
						got.status);
					errors++;
				end else begin
					outcome_t exp_o;
					exp_o = expected_outcomes.pop_front();
					if (got.addr !== exp_o.addr) begin
						$display("%0t: block_address expected %h actual %h", $time,
							exp_o.addr, got.addr);
						errors++;
					end
					if (got.status !== exp_o.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_o.status, got.status);
						errors++;
					end
				end
			end
			if (hold_sink) begin
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
				sink_gap <= $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_requests.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
			@(posedge clk);
	endtask

	// random content, mostly allocate and free of live blocks
	task automatic queue_random(int count);
		int sz, k;
		logic [15:0] ua;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45) begin
				sz = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
					: $urandom_range(1, 200);
				add_request(FUNC_ALLOC, sz, 16'($urandom));
			end else if (k < 90 && live_blocks.size() > 0) begin
				int idx;
				idx = $urandom_range(0, live_blocks.size() - 1);
				ua = 16'(live_blocks[idx]);
				live_blocks.delete(idx);
				add_request(FUNC_FREE, $urandom_range(0, 4095), ua);
			end else begin
				ua = 16'($urandom);
				wait_drained();
				if (free_is_safe(ua)) add_request(FUNC_FREE, $urandom_range(0, 4095), ua);
			end
		end
	endtask

	initial begin
		logic [15:0] a;
		for (int i = 0; i < CLASSES; i++) heads[i] = 0;
		for (int i = 0; i < POOL_GRAN; i++) begin
			words[i] = 0;
			written[i] = 1'b0;
		end
		cursor = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: size extremes, rejections, hits, frees of live blocks and link headers
		add_request(FUNC_ALLOC, 0, 16'h0000);
		add_request(FUNC_ALLOC, 4095, 16'hffff);
		add_request(FUNC_ALLOC, 4092, 16'h0000);
		add_request(FUNC_ALLOC, 4093, 16'h0000);
		add_request(FUNC_ALLOC, 1, 16'h0000);
		add_request(FUNC_ALLOC, 1, 16'h0000);
		add_request(FUNC_ALLOC, 4, 16'h0000);
		add_request(FUNC_ALLOC, 5, 16'h0000);
		add_request(FUNC_ALLOC, 2048, 16'h0000);
		add_request(FUNC_ALLOC, 1000, 16'h0000);
		add_request(FUNC_FREE, 0, 16'h1004);
		add_request(FUNC_FREE, 4095, 16'h1ffc);
		add_request(FUNC_FREE, 12'hfff, 16'h0004);
		add_request(FUNC_FREE, 0, 16'h100c);
		add_request(FUNC_FREE, 0, 16'h1014);
		add_request(FUNC_ALLOC, 1, 16'h0000);
		add_request(FUNC_ALLOC, 1, 16'h0000);
		add_request(FUNC_ALLOC, 1, 16'h0000);
		wait_drained();
		// free of header holding a link, gives a range error when not a size
		add_request(FUNC_FREE, 0, 16'h1ffc);

		// receiver holds off while requests keep coming
		for (int i = 0; i < 30; i++) add_request(FUNC_ALLOC, 24, 16'h0000);
		hold_sink = 1'b1;
		repeat (300) @(posedge clk);
		hold_sink = 1'b0;
		wait_drained();
		live_blocks.delete();

		queue_random(300);
		// sender pauses until everything is back
		wait_drained();
		repeat (20) @(posedge clk);

		// exhaust the pool with large blocks
		for (int i = 0; i < 20; i++) add_request(FUNC_ALLOC, $urandom_range(2100, 4092), 16'h0);
		queue_random(300);
		wait_drained();
		quiet_tail = 1'b1;
		queue_random(60);
		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d results: %0d allocations, %0d frees, %0d range, %0d out of pages",
			results_seen, n_alloc, n_free, n_range, n_nopage);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/scfla_pkg.sv
rtl/core/scfla_ram.sv
rtl/core/scfla_decode.sv
rtl/core/size_class_free_list_allocator.sv
test/size_class_free_list_allocator_tb.sv
